// ----- src/rsc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared constants, types and register codes of the cross-stencil sharpen unit.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int CH_W   = 8;                    // one color channel
    localparam int PIX_W  = 3 * CH_W;             // packed RGB pixel
    localparam int WID_W  = 11;                   // frame_width register
    localparam int HGT_W  = 13;                   // frame_height register
    localparam int COL_W  = $clog2(MAX_WIDTH);    // column position
    localparam int ROW_W  = 13;                   // saturating row position
    localparam int TOT_W  = WID_W + HGT_W;        // pixels per frame
    localparam int ADDR_W = 3;                    // APB byte address

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);
    localparam logic [WID_W-1:0] WIDTH_MAX    = WID_W'(MAX_WIDTH);
    localparam logic [HGT_W-1:0] HEIGHT_MAX   = HGT_W'(MAX_HEIGHT);

    // Register index, taken from byte address bit 2
    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    // Input opcodes
    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    // Neighbor enables of one stencil position (edge of frame masks to zero)
    typedef struct packed
    {
        logic lf_en;
        logic rt_en;
        logic up_en;
        logic dn_en;
    } stencil_ctl_t;

endpackage : rsc_pkg
`default_nettype wire

// ----- src/rsc_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_in_if
// Input pixel channel: valid/ready handshake with opcode and RGB payload.
// ----------------------------------------------------------------------------
interface rsc_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output opcode, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink   (input valid, input opcode, input red_in, input green_in,
                    input blue_in, output ready);
endinterface : rsc_in_if
`default_nettype wire

// ----- src/rsc_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_out_if
// Output pixel channel: valid/ready handshake with sharpened RGB and frame end.
// ----------------------------------------------------------------------------
interface rsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_end, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input frame_end, output ready);
endinterface : rsc_out_if
`default_nettype wire

// ----- src/rsc_line_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_line_cell
// One line-buffer cell: a row of pixels, read one row back, handed onward.
// ----------------------------------------------------------------------------
module rsc_line_cell
(
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [rsc_pkg::COL_W-1:0]  rd_addr,
    input  wire logic                       wr_en,
    input  wire logic [rsc_pkg::COL_W-1:0]  wr_addr,
    input  wire logic [rsc_pkg::PIX_W-1:0]  wr_data,
    output      logic [rsc_pkg::PIX_W-1:0]  rd_data
);
    import rsc_pkg::*;

    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_data_reg;

    // A write and a read of the same entry in one cycle: pass the new data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= line_mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule : rsc_line_cell
`default_nettype wire

// ----- src/rsc_channel_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_channel_cell
// One color channel of the stencil window with its sharpen-and-clamp datapath.
// ----------------------------------------------------------------------------
module rsc_channel_cell
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic                       restart,
    input  wire logic                       cfg_clear,
    input  wire rsc_pkg::stencil_ctl_t      ctl,
    input  wire logic [rsc_pkg::CH_W-1:0]   px,
    input  wire logic [rsc_pkg::CH_W-1:0]   mid,
    input  wire logic [rsc_pkg::CH_W-1:0]   top,
    output      logic [rsc_pkg::CH_W-1:0]   result
);
    import rsc_pkg::*;

    localparam int ACC_W = CH_W + 4;

    logic [CH_W-1:0] ctr_reg, ctr_next;
    logic [CH_W-1:0] up_reg, up_next;
    logic [CH_W-1:0] dn_reg, dn_next;
    logic [CH_W-1:0] lf_reg, lf_next;
    logic [CH_W-1:0] lf_val, rt_val, up_val, dn_val;
    logic [ACC_W-1:0] acc;

    always_comb
    begin
        ctr_next = ctr_reg;
        up_next  = up_reg;
        dn_next  = dn_reg;
        lf_next  = lf_reg;
        if (cfg_clear || (advance && restart))
        begin
            ctr_next = '0;
            up_next  = '0;
            dn_next  = '0;
            lf_next  = '0;
        end
        else if (advance)
        begin
            lf_next  = ctr_reg;
            ctr_next = mid;
            up_next  = top;
            dn_next  = px;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
            up_reg  <= '0;
            dn_reg  <= '0;
            lf_reg  <= '0;
        end
        else
        begin
            ctr_reg <= ctr_next;
            up_reg  <= up_next;
            dn_reg  <= dn_next;
            lf_reg  <= lf_next;
        end
    end

    // 5*center minus the four neighbors, then clamp to the channel range
    always_comb
    begin
        lf_val = ctl.lf_en ? lf_reg : '0;
        rt_val = ctl.rt_en ? mid    : '0;
        up_val = ctl.up_en ? up_reg : '0;
        dn_val = ctl.dn_en ? dn_reg : '0;
        acc = (ACC_W'(ctr_reg) << 2) + ACC_W'(ctr_reg)
            - ACC_W'(lf_val) - ACC_W'(rt_val) - ACC_W'(up_val) - ACC_W'(dn_val);
        if (acc[ACC_W-1])
        begin
            result = '0;
        end
        else if (acc[ACC_W-2:CH_W] != '0)
        begin
            result = '1;
        end
        else
        begin
            result = acc[CH_W-1:0];
        end
    end

endmodule : rsc_channel_cell
`default_nettype wire

// ----- src/rgb_sharpen_cross_stencil_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_sharpen_cross_stencil_unit
// Cross-kernel sharpen (5*center - left - up - down - right) on an RGB stream.
// ----------------------------------------------------------------------------
// Feed the frame in raster order, one pixel per transfer, then width+1 drain
// items (opcode 1) to flush it. The unit takes one item per clock cycle and
// gives one result per item once the first width+1 items of a frame are in;
// the last result of a frame carries frame_end, after which the next item
// starts a new frame. Pixels outside the frame count as zero and each channel
// is clamped to 0..255. An item's transfer registers it in the stencil stage
// with its line-buffer reads, and its result then moves into an output
// register, so the input keeps taking items while a result waits; the
// input stalls only when the stencil stage holds a result that cannot move on.
// The one-item-per-cycle figure is set by the single read and write port of
// each line buffer, which a same-entry bypass keeps whole for narrow frames.
// frame_width (address 0) and frame_height (address 4) take effect clamped to
// 1..1024 and 1..4096; a write restarts the frame and must come while idle.
// ----------------------------------------------------------------------------
module rgb_sharpen_cross_stencil_unit
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    rsc_in_if.sink                           pix_in,
    rsc_out_if.source                        pix_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rsc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output      logic [31:0]                 prdata,
    output      logic                        pready
);
    import rsc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WID_W-1:0] frame_width_reg, frame_width_next;
    logic [HGT_W-1:0] frame_height_reg, frame_height_next;
    logic             cfg_write;
    reg_index_t       cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = pwdata[WID_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = pwdata[HGT_W-1:0];
                default:          frame_width_next  = frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective frame size and pixel count
    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [TOT_W-1:0] total;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = WID_W'(1);
        else if (frame_width_reg > WIDTH_MAX)
            w_eff = WIDTH_MAX;
        else
            w_eff = frame_width_reg;

        if (frame_height_reg == '0)
            h_eff = HGT_W'(1);
        else if (frame_height_reg > HEIGHT_MAX)
            h_eff = HEIGHT_MAX;
        else
            h_eff = frame_height_reg;

        total = TOT_W'(w_eff) * TOT_W'(h_eff);
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_emit_reg;
    logic                s1_end_reg;
    stencil_ctl_t        s1_ctl_reg;
    logic [COL_W-1:0]    s1_addr_reg;
    logic [PIX_W-1:0]    s1_px_reg;
    logic                s1_adv;
    logic                in_acc;
    logic                out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]    out_px_reg;
    logic                out_end_reg;

    // Move the stencil stage on when it holds no result or the output can take it
    assign s1_adv = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || pix_out.ready);
    assign pix_in.ready = !s1_valid_reg || s1_adv;
    assign in_acc = pix_in.valid && pix_in.ready;

    // ------------------------------------------------------------------
    // Position tracking: decide everything about an item at its transfer
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [TOT_W-1:0] emitted_reg, emitted_next;

    logic [PIX_W-1:0] px_now;
    logic             valid_pos;
    logic             emit_now;
    logic             end_now;
    logic [COL_W-1:0] nc;
    logic [ROW_W-1:0] nr;
    stencil_ctl_t     ctl_now;

    always_comb
    begin
        // Drain items and anything past the last row act as a zero pixel
        if ((row_reg < ROW_W'(h_eff)) && (opcode_t'(pix_in.opcode) == OP_PIXEL))
            px_now = {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
        else
            px_now = '0;

        valid_pos = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && (col_reg != '0));
        emit_now  = valid_pos && (emitted_reg < total);
        end_now   = emit_now && ((emitted_reg + TOT_W'(1)) == total);

        // Position of the output pixel, one row and one column behind
        if (col_reg != '0)
        begin
            nc = col_reg - COL_W'(1);
            nr = row_reg - ROW_W'(1);
        end
        else
        begin
            nc = COL_W'(w_eff - WID_W'(1));
            nr = row_reg - ROW_W'(2);
        end
        ctl_now.lf_en = (nc != '0);
        ctl_now.rt_en = ((WID_W'(nc) + WID_W'(1)) < w_eff);
        ctl_now.up_en = (nr != '0);
        ctl_now.dn_en = (({1'b0, nr} + (ROW_W+1)'(1)) < (ROW_W+1)'(h_eff));
    end

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        emitted_next = emitted_reg;
        if (cfg_write || (in_acc && end_now))
        begin
            // Restart the frame
            col_next     = '0;
            row_next     = '0;
            emitted_next = '0;
        end
        else if (in_acc)
        begin
            if (emit_now)
                emitted_next = emitted_reg + TOT_W'(1);
            if ((WID_W'(col_reg) + WID_W'(1)) >= w_eff)
            begin
                col_next = '0;
                if (row_reg != '1)
                    row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stencil stage and output register
    // ------------------------------------------------------------------
    logic [CH_W-1:0] res_r, res_g, res_b;

    always_comb
    begin
        if (in_acc)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv && s1_emit_reg)
            out_valid_next = 1'b1;
        else if (pix_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            emitted_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            emitted_reg      <= emitted_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload: hold unless a new item or result moves in
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_emit_reg <= emit_now;
            s1_end_reg  <= end_now;
            s1_ctl_reg  <= ctl_now;
            s1_addr_reg <= col_reg;
            s1_px_reg   <= px_now;
        end
        if (s1_adv && s1_emit_reg)
        begin
            out_px_reg  <= {res_r, res_g, res_b};
            out_end_reg <= s1_end_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line-buffer chain: input -> row above -> row two above
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] mid_px;
    logic [PIX_W-1:0] top_px;

    rsc_line_cell u_line_above
    (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_px_reg),
        .rd_data (mid_px)
    );

    rsc_line_cell u_line_two_above
    (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (mid_px),
        .rd_data (top_px)
    );

    // ------------------------------------------------------------------
    // Window and sharpen, one cell per channel
    // ------------------------------------------------------------------
    rsc_channel_cell u_chan_red
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_adv),
        .restart   (s1_end_reg),
        .cfg_clear (cfg_write),
        .ctl       (s1_ctl_reg),
        .px        (s1_px_reg[3*CH_W-1:2*CH_W]),
        .mid       (mid_px[3*CH_W-1:2*CH_W]),
        .top       (top_px[3*CH_W-1:2*CH_W]),
        .result    (res_r)
    );

    rsc_channel_cell u_chan_green
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_adv),
        .restart   (s1_end_reg),
        .cfg_clear (cfg_write),
        .ctl       (s1_ctl_reg),
        .px        (s1_px_reg[2*CH_W-1:CH_W]),
        .mid       (mid_px[2*CH_W-1:CH_W]),
        .top       (top_px[2*CH_W-1:CH_W]),
        .result    (res_g)
    );

    rsc_channel_cell u_chan_blue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_adv),
        .restart   (s1_end_reg),
        .cfg_clear (cfg_write),
        .ctl       (s1_ctl_reg),
        .px        (s1_px_reg[CH_W-1:0]),
        .mid       (mid_px[CH_W-1:0]),
        .top       (top_px[CH_W-1:0]),
        .result    (res_b)
    );

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red_out   = out_px_reg[3*CH_W-1:2*CH_W];
    assign pix_out.green_out = out_px_reg[2*CH_W-1:CH_W];
    assign pix_out.blue_out  = out_px_reg[CH_W-1:0];
    assign pix_out.frame_end = out_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        WID_W'(col_reg) < w_eff)
        else $error("column position beyond frame width");

    a_emitted_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg < total)
        else $error("result count reached frame size without restart");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && end_now && !cfg_write) |=>
            (col_reg == '0 && row_reg == '0 && emitted_reg == '0))
        else $error("frame end did not restart position tracking");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit_reg && out_valid_reg && !pix_out.ready) |=>
            (s1_valid_reg && $stable(s1_addr_reg) && $stable(s1_px_reg)))
        else $error("stencil stage lost a result while output was blocked");

endmodule : rgb_sharpen_cross_stencil_unit
`default_nettype wire
